// ===== rtl/ibin_pkg.sv =====
// ----------------------------------------------------------------------------
// Image block binning package
// Shared sizes, register codes and the control record passed from the
// position counters to the summing datapath.
// ----------------------------------------------------------------------------
package ibin_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_BIN     = 16;
    localparam int SAMPLE_BITS = 32;

    localparam int SUM_W   = 40;
    localparam int POS_W   = 12;
    localparam int DIM_W   = 13;
    localparam int BIN_W   = 5;
    localparam int INBIN_W = 4;
    localparam int OFS_W   = 12;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);

    typedef enum logic [IDX_W-1:0] {
        REG_BIN_SIZE     = 3'd0,
        REG_FRAME_WIDTH  = 3'd1,
        REG_FRAME_HEIGHT = 3'd2,
        REG_OFFSET_COL   = 3'd3,
        REG_OFFSET_ROW   = 3'd4
    } ibin_reg_t;

    typedef struct packed {
        logic             binned;
        logic             close;
        logic             need_read;
        logic             emit;
        logic             last;
        logic             line_end;
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] row_idx;
    } ibin_ctl_t;

endpackage

// ===== rtl/ibin_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data, which holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module ibin_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ibin_ctrl.sv =====
// ----------------------------------------------------------------------------
// Image block binning control
// Configuration registers and the frame, block and in-block position
// counters. Decodes, for the item being accepted, what the datapath does.
// ----------------------------------------------------------------------------
module ibin_ctrl import ibin_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             accept,
    output logic             restart,
    output ibin_ctl_t        ctl
);

    logic [BIN_W-1:0]   bin_size_reg;
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [OFS_W-1:0]   offset_col_reg;
    logic [OFS_W-1:0]   offset_row_reg;

    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic [INBIN_W-1:0] ibc_reg, ibc_next;
    logic [INBIN_W-1:0] ibr_reg, ibr_next;
    logic [POS_W-1:0]   bci_reg, bci_next;
    logic [POS_W-1:0]   bri_reg, bri_next;

    logic [BIN_W-1:0]   b_eff;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic               row_in;
    logic               row_end;
    logic               bin_row_end;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        restart = 1'b0;
        case (cfg_index)
            REG_BIN_SIZE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT,
            REG_OFFSET_COL, REG_OFFSET_ROW: restart = cfg_valid;
            default:                        restart = 1'b0;
        endcase
    end

    // Out-of-range sizes are clamped rather than rejected.
    always_comb
    begin
        if (bin_size_reg == '0)
            b_eff = BIN_W'(1);
        else if (bin_size_reg > BIN_W'(MAX_BIN))
            b_eff = BIN_W'(MAX_BIN);
        else
            b_eff = bin_size_reg;

        if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;

        if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    always_comb
    begin
        row_in        = row_reg >= offset_row_reg;
        ctl.binned    = (col_reg >= offset_col_reg) && row_in;
        ctl.close     = ctl.binned && ((BIN_W'(ibc_reg) + BIN_W'(1)) >= b_eff);
        ctl.need_read = ctl.close && (ibr_reg != '0);
        bin_row_end   = (BIN_W'(ibr_reg) + BIN_W'(1)) >= b_eff;
        ctl.emit      = ctl.close && bin_row_end;
        ctl.last      = ((DIM_W'(col_reg) + DIM_W'(b_eff)) >= w_eff)
                        && ((DIM_W'(row_reg) + DIM_W'(b_eff)) >= h_eff);
        ctl.line_end  = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
        row_end       = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;
        ctl.idx       = bci_reg;
        ctl.row_idx   = bri_reg;
    end

    always_comb
    begin
        col_next = col_reg + POS_W'(1);
        row_next = row_reg;
        ibc_next = ibc_reg;
        ibr_next = ibr_reg;
        bci_next = bci_reg;
        bri_next = bri_reg;

        if (ctl.close)
        begin
            ibc_next = '0;
            bci_next = bci_reg + POS_W'(1);
        end
        else if (ctl.binned)
        begin
            ibc_next = ibc_reg + INBIN_W'(1);
        end

        if (ctl.line_end)
        begin
            col_next = '0;
            ibc_next = '0;
            bci_next = '0;
            if (row_in)
            begin
                if (bin_row_end)
                begin
                    ibr_next = '0;
                    bri_next = bri_reg + POS_W'(1);
                end
                else
                begin
                    ibr_next = ibr_reg + INBIN_W'(1);
                end
            end
            if (row_end)
            begin
                row_next = '0;
                ibr_next = '0;
                bri_next = '0;
            end
            else
            begin
                row_next = row_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_size_reg     <= BIN_W'(1);
            frame_width_reg  <= DIM_W'(MAX_WIDTH);
            frame_height_reg <= DIM_W'(MAX_HEIGHT);
            offset_col_reg   <= '0;
            offset_row_reg   <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            ibc_reg          <= '0;
            ibr_reg          <= '0;
            bci_reg          <= '0;
            bri_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BIN_SIZE:     bin_size_reg     <= cfg_data[BIN_W-1:0];
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                    REG_OFFSET_COL:   offset_col_reg   <= cfg_data[OFS_W-1:0];
                    REG_OFFSET_ROW:   offset_row_reg   <= cfg_data[OFS_W-1:0];
                    default:          ;
                endcase
            end

            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                ibc_reg <= '0;
                ibr_reg <= '0;
                bci_reg <= '0;
                bri_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                ibc_reg <= ibc_next;
                ibr_reg <= ibr_next;
                bci_reg <= bci_next;
                bri_reg <= bri_next;
            end
        end
    end

endmodule

// ===== rtl/ibin_acc.sv =====
// ----------------------------------------------------------------------------
// Image block binning accumulator
// Input register, horizontal running sum, line store update and the
// result register that parts the input side from the output side.
// ----------------------------------------------------------------------------
module ibin_acc import ibin_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  ibin_ctl_t                     ctl,
    input  logic                          restart,
    input  logic [SUM_W-1:0]              rd_data,
    output logic                          we,
    output logic [ADDR_W-1:0]             waddr,
    output logic [SUM_W-1:0]              wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SUM_W-1:0]       bin_sum,
    output logic [POS_W-1:0]              bin_col,
    output logic [POS_W-1:0]              bin_row,
    output logic                          frame_last
);

    logic                    st_valid_reg;
    ibin_ctl_t               st_ctl_reg;
    logic [SAMPLE_BITS-1:0]  st_sample_reg;
    logic [SUM_W-1:0]        rps_reg;
    logic                    res_valid_reg;
    logic [SUM_W-1:0]        res_sum_reg;
    logic [POS_W-1:0]        res_col_reg;
    logic [POS_W-1:0]        res_row_reg;
    logic                    res_last_reg;

    logic                    advance;
    logic                    accept;
    logic [SUM_W-1:0]        acc;
    logic [SUM_W-1:0]        total;

    assign advance  = st_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !st_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign acc   = rps_reg + SUM_W'(signed'(st_sample_reg));
    assign total = st_ctl_reg.need_read ? (rd_data + acc) : acc;

    assign we    = advance && st_ctl_reg.close;
    assign waddr = st_ctl_reg.idx[ADDR_W-1:0];
    assign wdata = total;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_ctl_reg    <= ctl;
            st_sample_reg <= sample;
        end
        if (advance && st_ctl_reg.emit)
        begin
            res_sum_reg  <= total;
            res_col_reg  <= st_ctl_reg.idx;
            res_row_reg  <= st_ctl_reg.row_idx;
            res_last_reg <= st_ctl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            rps_reg       <= '0;
        end
        else
        begin
            if (accept)
                st_valid_reg <= 1'b1;
            else if (advance)
                st_valid_reg <= 1'b0;

            if (advance && st_ctl_reg.emit)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;

            // The running sum restarts at every block boundary, line end and frame restart.
            if (restart)
                rps_reg <= '0;
            else if (advance)
            begin
                if (st_ctl_reg.line_end || st_ctl_reg.close)
                    rps_reg <= '0;
                else if (st_ctl_reg.binned)
                    rps_reg <= acc;
            end
        end
    end

    assign out_valid  = res_valid_reg;
    assign bin_sum    = res_sum_reg;
    assign bin_col    = res_col_reg;
    assign bin_row    = res_row_reg;
    assign frame_last = res_last_reg;

endmodule

// ===== rtl/image_block_binning_core.sv =====
// ----------------------------------------------------------------------------
// Image block binning core
// Crops a raster stream of signed samples and sums each full square block.
// ----------------------------------------------------------------------------
// The core takes one sample per clock cycle unless a result is left standing in
// the result register. A result is presented once the item that completes a
// block has passed the input register into the result register, provided the
// previous result has been taken. The line store is a 4096 by 40-bit RAM with
// one read and one write port. It is read when an item that needs an earlier
// column sum is accepted and written when an item that closes a block column
// leaves the input register. Line store entries are only read after they have
// been written in the same block row, so no clearing pass is needed after
// reset. A configuration write to any of the five registers restarts the
// frame; configure only while the core is idle.
module image_block_binning_core import ibin_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SUM_W-1:0]       bin_sum,
    output logic [POS_W-1:0]              bin_col,
    output logic [POS_W-1:0]              bin_row,
    output logic                          frame_last
);

    ibin_ctl_t         ctl;
    logic              restart;
    logic              accept;
    logic              ram_re;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [SUM_W-1:0]  ram_rdata;

    assign accept = in_valid && in_ready;
    assign ram_re = accept && ctl.need_read;

    ibin_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .restart   (restart),
        .ctl       (ctl)
    );

    ibin_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ctl.idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ibin_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .ctl        (ctl),
        .restart    (restart),
        .rd_data    (ram_rdata),
        .we         (ram_we),
        .waddr      (ram_waddr),
        .wdata      (ram_wdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_sum    (bin_sum),
        .bin_col    (bin_col),
        .bin_row    (bin_row),
        .frame_last (frame_last)
    );

    // A column sum is never read in the same cycle as it is being updated.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && ram_we && (ram_waddr == ctl.idx[ADDR_W-1:0])))
        else $error("line store read collides with write");

    // With the result register empty the input side must never stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A new result can only come from an item that moved on last cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without an item advancing");

endmodule
